### design/jtag_tap_scan_master_unit_assert.svh
// assertion macros shared by the checker
`ifndef JTAG_TAP_SCAN_MASTER_UNIT_ASSERT_SVH
`define JTAG_TAP_SCAN_MASTER_UNIT_ASSERT_SVH

// antecedent and consequent checked at the same edge
`define JTSM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked at the edge after the antecedent
`define JTSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/jtsm_pkg.sv
package jtsm_pkg;

   localparam int BYTE_BITS        = 8;
   localparam int RESET_TMS_CYCLES = 6;
   localparam int MAX_RESET_ONES   = 12;
   localparam int STEP_W           = 4;
   localparam int REQ_TDATA_W      = 32;
   localparam int RSP_TDATA_W      = 24;

   typedef logic [4:0] tap_state_type;

   localparam tap_state_type TAP_SHIFT_DR = 5'd2;
   localparam tap_state_type TAP_SHIFT_IR = 5'd10;
   localparam tap_state_type TAP_IDLE     = 5'd12;
   localparam tap_state_type TAP_TLR      = 5'd15;
   localparam tap_state_type TAP_UNDEF    = 5'd16;

   typedef enum logic [1:0] {
      ACT_RESET,
      ACT_TMS_SEQ,
      ACT_SHIFT_IR,
      ACT_SHIFT_DR
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_BAD_PARAM,
      STAT_BAD_STATE
   } status_type;

   typedef enum logic [2:0] {
      PK_STATUS,
      PK_RST_ONE,
      PK_TMS_ZERO,
      PK_TMS_ONE,
      PK_SEQ,
      PK_DATA
   } pulse_kind_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_DECODE,
      CS_RST_ONE,
      CS_RST_ZERO,
      CS_SEQ,
      CS_ENTRY,
      CS_SHIFT,
      CS_EXIT,
      CS_STATUS
   } ctrl_state_type;

   typedef struct packed {
      logic           load;
      logic           emit;
      pulse_kind_type kind;
      logic           rst_final;
      logic           run_end;
      logic [2:0]     bit_idx;
      logic           last_bit;
   } dp_cmd_type;

   typedef struct packed {
      logic       slot_free;
      action_type action;
      logic       first_byte;
      logic       last_byte;
      logic [3:0] bit_len;
      status_type err;
   } dp_stat_type;

   // one TAP transition; undefined state stays undefined
   function automatic tap_state_type tap_advance(tap_state_type s, logic tms);
      tap_state_type n;
      n = s;
      case (s)
         5'd0:    n = tms ? 5'd5  : 5'd2;
         5'd1:    n = tms ? 5'd5  : 5'd3;
         5'd2:    n = tms ? 5'd1  : 5'd2;
         5'd3:    n = tms ? 5'd0  : 5'd3;
         5'd4:    n = tms ? 5'd15 : 5'd14;
         5'd5:    n = tms ? 5'd7  : 5'd12;
         5'd6:    n = tms ? 5'd1  : 5'd2;
         5'd7:    n = tms ? 5'd4  : 5'd6;
         5'd8:    n = tms ? 5'd13 : 5'd10;
         5'd9:    n = tms ? 5'd13 : 5'd11;
         5'd10:   n = tms ? 5'd9  : 5'd10;
         5'd11:   n = tms ? 5'd8  : 5'd11;
         5'd12:   n = tms ? 5'd7  : 5'd12;
         5'd13:   n = tms ? 5'd7  : 5'd12;
         5'd14:   n = tms ? 5'd9  : 5'd10;
         5'd15:   n = tms ? 5'd15 : 5'd12;
         default: n = s;
      endcase
      return n;
   endfunction

   // captured tdo in the low bits, outgoing data above
   function automatic logic [7:0] merge_read(logic [7:0] obyte, logic [7:0] tdo,
                                             logic [3:0] bc);
      logic [8:0] ones;
      logic [7:0] mask;
      ones = (9'd1 << bc) - 9'd1;
      mask = ones[7:0];
      return (tdo & mask) | (obyte & ~mask);
   endfunction

endpackage

### design/jtsm_dpath.sv
module jtsm_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [jtsm_pkg::REQ_TDATA_W-1:0]       req_tdata,
   input  logic [2:0]                             req_tuser,
   input  logic                                   req_tlast,
   input  jtsm_pkg::dp_cmd_type                   cmd,
   output jtsm_pkg::dp_stat_type                  stat,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [jtsm_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tuser,
   output logic                                   rsp_tlast
);

   // latched transaction
   jtsm_pkg::action_type    act_ff, act_in;
   logic [7:0]              tms_bits_ff, tms_bits_in;
   logic [3:0]              bit_len_ff, bit_len_in;
   logic [7:0]              out_byte_ff, out_byte_in;
   logic [7:0]              tdo_bits_ff, tdo_bits_in;
   logic                    first_ff, first_in;
   logic                    last_ff, last_in;

   jtsm_pkg::tap_state_type tap_ff, tap_in;

   // output register
   logic                    valid_ff, valid_in;
   logic                    o_clk_ff, o_clk_in;
   logic                    o_tms_ff, o_tms_in;
   logic                    o_tdi_ff, o_tdi_in;
   logic                    o_end_ff, o_end_in;
   jtsm_pkg::status_type    o_status_ff, o_status_in;
   logic [7:0]              o_read_ff, o_read_in;
   jtsm_pkg::tap_state_type o_state_ff, o_state_in;

   logic                    pulse_tms;
   logic                    pulse_tdi;
   logic                    pulse_clk;
   jtsm_pkg::tap_state_type pulse_state;
   jtsm_pkg::status_type    err;
   jtsm_pkg::tap_state_type need_state;
   logic                    is_shift;
   logic                    slot_free;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      act_in       = act_ff;
      tms_bits_in  = tms_bits_ff;
      bit_len_in   = bit_len_ff;
      out_byte_in  = out_byte_ff;
      tdo_bits_in  = tdo_bits_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      if (cmd.load) begin
         act_in       = jtsm_pkg::action_type'(req_tuser[1:0]);
         tms_bits_in  = req_tdata[7:0];
         bit_len_in   = req_tdata[11:8];
         out_byte_in  = req_tdata[19:12];
         tdo_bits_in  = req_tdata[27:20];
         first_in     = req_tuser[2];
         last_in      = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      tms_bits_ff  <= tms_bits_in;
      bit_len_ff   <= bit_len_in;
      out_byte_ff  <= out_byte_in;
      tdo_bits_ff  <= tdo_bits_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
   end

   // parameter and state checks on the latched transaction
   assign is_shift = (act_ff == jtsm_pkg::ACT_SHIFT_IR) || (act_ff == jtsm_pkg::ACT_SHIFT_DR);

   always_comb begin
      err = jtsm_pkg::STAT_OK;
      if (first_ff) begin
         need_state = jtsm_pkg::TAP_IDLE;
      end else if (act_ff == jtsm_pkg::ACT_SHIFT_IR) begin
         need_state = jtsm_pkg::TAP_SHIFT_IR;
      end else begin
         need_state = jtsm_pkg::TAP_SHIFT_DR;
      end
      case (act_ff)
         jtsm_pkg::ACT_RESET: begin
            err = jtsm_pkg::STAT_OK;
         end
         jtsm_pkg::ACT_TMS_SEQ: begin
            if (bit_len_ff > 4'(jtsm_pkg::BYTE_BITS)) begin
               err = jtsm_pkg::STAT_BAD_PARAM;
            end else if (tap_ff > jtsm_pkg::TAP_TLR) begin
               err = jtsm_pkg::STAT_BAD_STATE;
            end
         end
         default: begin
            // a one-bit ir scan is too short to be legal
            if ((bit_len_ff == 4'd0) || (bit_len_ff > 4'(jtsm_pkg::BYTE_BITS)) ||
                ((act_ff == jtsm_pkg::ACT_SHIFT_IR) && first_ff && last_ff &&
                 (bit_len_ff <= 4'd1))) begin
               err = jtsm_pkg::STAT_BAD_PARAM;
            end else if (tap_ff != need_state) begin
               err = jtsm_pkg::STAT_BAD_STATE;
            end
         end
      endcase
   end

   always_comb begin
      stat.slot_free  = slot_free;
      stat.action     = act_ff;
      stat.first_byte = first_ff;
      stat.last_byte  = last_ff;
      stat.bit_len    = bit_len_ff;
      stat.err        = err;
   end

   // pin levels and next tap state for the result being issued
   always_comb begin
      pulse_clk   = 1'b1;
      pulse_tms   = 1'b0;
      pulse_tdi   = 1'b0;
      pulse_state = tap_ff;
      case (cmd.kind)
         jtsm_pkg::PK_STATUS: begin
            pulse_clk = 1'b0;
         end
         jtsm_pkg::PK_RST_ONE: begin
            pulse_tms   = 1'b1;
            pulse_state = cmd.rst_final ? jtsm_pkg::TAP_TLR : jtsm_pkg::TAP_UNDEF;
         end
         jtsm_pkg::PK_TMS_ZERO: begin
            pulse_state = jtsm_pkg::tap_advance(tap_ff, 1'b0);
         end
         jtsm_pkg::PK_TMS_ONE: begin
            pulse_tms   = 1'b1;
            pulse_state = jtsm_pkg::tap_advance(tap_ff, 1'b1);
         end
         jtsm_pkg::PK_SEQ: begin
            pulse_tms   = tms_bits_ff[cmd.bit_idx];
            pulse_state = jtsm_pkg::tap_advance(tap_ff, pulse_tms);
         end
         jtsm_pkg::PK_DATA: begin
            pulse_tms   = cmd.last_bit;
            pulse_tdi   = out_byte_ff[cmd.bit_idx];
            pulse_state = jtsm_pkg::tap_advance(tap_ff, pulse_tms);
         end
         default: begin
            pulse_clk = 1'b0;
         end
      endcase
   end

   always_comb begin
      tap_in      = tap_ff;
      valid_in    = valid_ff && !rsp_tready;
      o_clk_in    = o_clk_ff;
      o_tms_in    = o_tms_ff;
      o_tdi_in    = o_tdi_ff;
      o_end_in    = o_end_ff;
      o_status_in = o_status_ff;
      o_read_in   = o_read_ff;
      o_state_in  = o_state_ff;
      if (cmd.emit) begin
         tap_in      = pulse_state;
         valid_in    = 1'b1;
         o_clk_in    = pulse_clk;
         o_tms_in    = pulse_tms;
         o_tdi_in    = pulse_tdi;
         o_end_in    = cmd.run_end;
         o_status_in = (cmd.kind == jtsm_pkg::PK_STATUS) ? err : jtsm_pkg::STAT_OK;
         o_state_in  = pulse_state;
         if (cmd.run_end && is_shift && (cmd.kind != jtsm_pkg::PK_STATUS)) begin
            o_read_in = jtsm_pkg::merge_read(out_byte_ff, tdo_bits_ff, bit_len_ff);
         end else begin
            o_read_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff   <= jtsm_pkg::TAP_UNDEF;
         valid_ff <= 1'b0;
      end else begin
         tap_ff   <= tap_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      o_clk_ff    <= o_clk_in;
      o_tms_ff    <= o_tms_in;
      o_tdi_ff    <= o_tdi_in;
      o_end_ff    <= o_end_in;
      o_status_ff <= o_status_in;
      o_read_ff   <= o_read_in;
      o_state_ff  <= o_state_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = o_clk_ff;
   assign rsp_tlast  = o_end_ff;
   assign rsp_tdata  = {7'd0, o_state_ff, o_read_ff, o_status_ff, o_tdi_ff, o_tms_ff};

endmodule

### design/jtsm_ctrl.sv
module jtsm_ctrl #(
   parameter int RESET_TMS_CYCLES = jtsm_pkg::RESET_TMS_CYCLES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  jtsm_pkg::dp_stat_type stat,
   output jtsm_pkg::dp_cmd_type  cmd
);

   localparam int RstOnesHi = (RESET_TMS_CYCLES > jtsm_pkg::MAX_RESET_ONES) ?
                              jtsm_pkg::MAX_RESET_ONES : RESET_TMS_CYCLES;
   localparam int RstOnes   = (RstOnesHi < 1) ? 1 : RstOnesHi;
   localparam logic [jtsm_pkg::STEP_W-1:0] RstLast = jtsm_pkg::STEP_W'(RstOnes - 1);

   jtsm_pkg::ctrl_state_type     state_ff, state_in;
   logic [jtsm_pkg::STEP_W-1:0]  step_ff, step_in;

   logic                         is_ir;
   logic                         bit_end;
   logic                         entry_end;

   assign is_ir     = (stat.action == jtsm_pkg::ACT_SHIFT_IR);
   assign bit_end   = (step_ff == (stat.bit_len - 4'd1));
   // ir entry: 1,1,0,0  dr entry: 1,0,0
   assign entry_end = is_ir ? (step_ff == 4'd3) : (step_ff == 4'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jtsm_pkg::CS_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.kind     = jtsm_pkg::PK_STATUS;
      cmd.bit_idx  = step_ff[2:0];
      case (state_ff)
         jtsm_pkg::CS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = jtsm_pkg::CS_DECODE;
            end
         end
         jtsm_pkg::CS_DECODE: begin
            step_in = '0;
            case (stat.action)
               jtsm_pkg::ACT_RESET: begin
                  state_in = jtsm_pkg::CS_RST_ONE;
               end
               jtsm_pkg::ACT_TMS_SEQ: begin
                  if ((stat.err != jtsm_pkg::STAT_OK) || (stat.bit_len == 4'd0)) begin
                     state_in = jtsm_pkg::CS_STATUS;
                  end else begin
                     state_in = jtsm_pkg::CS_SEQ;
                  end
               end
               default: begin
                  if (stat.err != jtsm_pkg::STAT_OK) begin
                     state_in = jtsm_pkg::CS_STATUS;
                  end else if (stat.first_byte) begin
                     state_in = jtsm_pkg::CS_ENTRY;
                  end else begin
                     state_in = jtsm_pkg::CS_SHIFT;
                  end
               end
            endcase
         end
         jtsm_pkg::CS_RST_ONE: begin
            cmd.kind      = jtsm_pkg::PK_RST_ONE;
            cmd.rst_final = (step_ff == RstLast);
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               if (cmd.rst_final) begin
                  step_in  = '0;
                  state_in = jtsm_pkg::CS_RST_ZERO;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         jtsm_pkg::CS_RST_ZERO: begin
            cmd.kind    = jtsm_pkg::PK_TMS_ZERO;
            cmd.run_end = (step_ff == 4'd1);
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               step_in  = step_ff + 4'd1;
               if (cmd.run_end) begin
                  state_in = jtsm_pkg::CS_IDLE;
               end
            end
         end
         jtsm_pkg::CS_SEQ: begin
            cmd.kind    = jtsm_pkg::PK_SEQ;
            cmd.run_end = bit_end;
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               step_in  = step_ff + 4'd1;
               if (bit_end) begin
                  state_in = jtsm_pkg::CS_IDLE;
               end
            end
         end
         jtsm_pkg::CS_ENTRY: begin
            if ((step_ff == 4'd0) || (is_ir && (step_ff == 4'd1))) begin
               cmd.kind = jtsm_pkg::PK_TMS_ONE;
            end else begin
               cmd.kind = jtsm_pkg::PK_TMS_ZERO;
            end
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               if (entry_end) begin
                  step_in  = '0;
                  state_in = jtsm_pkg::CS_SHIFT;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         jtsm_pkg::CS_SHIFT: begin
            cmd.kind     = jtsm_pkg::PK_DATA;
            cmd.last_bit = bit_end && stat.last_byte;
            cmd.run_end  = bit_end && !stat.last_byte;
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               if (bit_end) begin
                  step_in  = '0;
                  state_in = stat.last_byte ? jtsm_pkg::CS_EXIT : jtsm_pkg::CS_IDLE;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         jtsm_pkg::CS_EXIT: begin
            // exit1 -> update -> idle
            cmd.kind    = (step_ff == 4'd0) ? jtsm_pkg::PK_TMS_ONE : jtsm_pkg::PK_TMS_ZERO;
            cmd.run_end = (step_ff == 4'd1);
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               step_in  = step_ff + 4'd1;
               if (cmd.run_end) begin
                  state_in = jtsm_pkg::CS_IDLE;
               end
            end
         end
         jtsm_pkg::CS_STATUS: begin
            cmd.kind    = jtsm_pkg::PK_STATUS;
            cmd.run_end = 1'b1;
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               state_in = jtsm_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = jtsm_pkg::CS_IDLE;
         end
      endcase
   end

endmodule

### design/jtag_tap_scan_master_unit.sv
// JTAG scan master: each request transaction is a reset, a TMS sequence or
// one byte of an IR/DR scan, and it turns into a run of response
// transactions, one per TCK pulse (or a single status-only response when
// the command is rejected or is a TMS sequence of length zero), the last one
// flagged by rsp_tlast. The block handles one request at a time: a request is
// taken, decoded in the next cycle, and then one response is issued per clock
// while the response side keeps up. Reset gives RESET_TMS_CYCLES (capped at
// 12) plus two pulses; a scan byte gives up to four entry, eight data and two
// exit pulses, fourteen at most. The TAP state starts undefined (16) until a
// reset command is run.
module jtag_tap_scan_master_unit #(
   parameter int RESET_TMS_CYCLES = jtsm_pkg::RESET_TMS_CYCLES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tms_bits[7:0], bit_len[11:8], out_byte[19:12], tdo_bits[27:20], zero pad
   input  logic [jtsm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action[1:0], first_byte[2]
   input  logic [2:0]                       req_tuser,
   // last_byte
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pin_tms[0], pin_tdi[1], status[3:2], read_byte[11:4], state_now[16:12], zero pad
   output logic [jtsm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // drives_clock
   output logic                             rsp_tuser,
   // run_end
   output logic                             rsp_tlast
);

   jtsm_pkg::dp_cmd_type  cmd;
   jtsm_pkg::dp_stat_type stat;

   jtsm_ctrl #(
      .RESET_TMS_CYCLES(RESET_TMS_CYCLES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   jtsm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/jtsm_checker.sv
`include "jtag_tap_scan_master_unit_assert.svh"

module jtsm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [jtsm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [2:0]                       req_tuser,
   input logic                             req_tlast,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [jtsm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   // one request in flight: no second request right behind the first
   `JTSM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

   // a response without a pulse is always the end of its run
   `JTSM_ASSERT_SAME(a_status_ends_run, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast, "status-only response not last")

   // an error code only appears on a status-only, final response
   `JTSM_ASSERT_SAME(a_error_no_pulse, clock, reset, rsp_tvalid && (rsp_tdata[3:2] != 2'b00), rsp_tlast && !rsp_tuser, "error on a pulse")

   // a stalled response holds
   `JTSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled response changed")

endmodule

bind jtag_tap_scan_master_unit jtsm_checker u_jtsm_checker (.*);
